// ----- design/p2a_pkg.sv -----
// shared types, constants and helper functions for the pixel to ascii art stream
// no dependencies
package p2a_pkg;

    // default sizing
    localparam int MAX_COLUMNS_DEFAULT        = 80;
    localparam int COORD_BITS_DEFAULT         = 12;
    localparam int STEP_FRACTION_BITS_DEFAULT = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] CFG_COLOR_MODE    = 3'd3;
    localparam logic [2:0] CFG_COLUMN_STEP   = 3'd4;

    // text bytes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;

    // bt.709 luminance weights, q16
    localparam logic [23:0] LUMA_RED   = 24'd13933;
    localparam logic [23:0] LUMA_GREEN = 24'd46871;
    localparam logic [23:0] LUMA_BLUE  = 24'd4732;
    localparam int unsigned LUMA_FULL  = 255 * 65536;
    localparam int          RAMP_STEPS = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_LUMA,
        ST_PRE,
        ST_RED,
        ST_SEP_G,
        ST_GRN,
        ST_SEP_B,
        ST_BLU,
        ST_TERM,
        ST_CHAR,
        ST_RST
    } ctrl_state_t;

    typedef struct packed {
        logic        ready;
        logic        emit;
        ctrl_state_t seg;
        logic [2:0]  idx;
        logic        last;
        logic        line_end;
    } p2a_cmd_t;

    typedef struct packed {
        logic       sampled;
        logic       out_free;
        logic       color;
        logic       close;
        logic [1:0] ndig_red;
        logic [1:0] ndig_green;
        logic [1:0] ndig_blue;
    } p2a_status_t;

    // smallest luminance that reaches ramp step k
    function automatic logic [23:0] luma_threshold(input int unsigned k);
        return 24'((k * LUMA_FULL + 8) / 9);
    endfunction

    function automatic logic [7:0] ramp_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h20;
            4'd1:    c = 8'h2E;
            4'd2:    c = 8'h3A;
            4'd3:    c = 8'h2D;
            4'd4:    c = 8'h3D;
            4'd5:    c = 8'h2B;
            4'd6:    c = 8'h2A;
            4'd7:    c = 8'h23;
            4'd8:    c = 8'h25;
            4'd9:    c = 8'h40;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

// ----- design/p2a_ctrl.sv -----
// controller state machine: sequences color math and text word emission
// depends on p2a_pkg
module p2a_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  p2a_pkg::p2a_status_t status,
    output p2a_pkg::p2a_cmd_t    cmd
);

    p2a_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] seg_len;
    logic       seg_end;
    logic       is_emit;
    logic       with_reset;

    assign with_reset = status.color && status.close;

    always_comb
    begin
        case (state_reg)
            p2a_pkg::ST_PRE: seg_len = 3'd7;
            p2a_pkg::ST_RED: seg_len = {1'b0, status.ndig_red};
            p2a_pkg::ST_GRN: seg_len = {1'b0, status.ndig_green};
            p2a_pkg::ST_BLU: seg_len = {1'b0, status.ndig_blue};
            p2a_pkg::ST_RST: seg_len = 3'd4;
            default:         seg_len = 3'd1;
        endcase
    end

    assign seg_end = (idx_reg == seg_len - 3'd1);
    assign is_emit = (state_reg != p2a_pkg::ST_IDLE) && (state_reg != p2a_pkg::ST_MIX)
                  && (state_reg != p2a_pkg::ST_LUMA);

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            p2a_pkg::ST_IDLE:
            begin
                if (status.sampled)
                    state_next = p2a_pkg::ST_MIX;
            end
            p2a_pkg::ST_MIX:
                state_next = p2a_pkg::ST_LUMA;
            p2a_pkg::ST_LUMA:
            begin
                idx_next   = 3'd0;
                state_next = status.color ? p2a_pkg::ST_PRE : p2a_pkg::ST_CHAR;
            end
            default:
            begin
                if (status.out_free)
                begin
                    if (seg_end)
                    begin
                        idx_next = 3'd0;
                        case (state_reg)
                            p2a_pkg::ST_PRE:   state_next = p2a_pkg::ST_RED;
                            p2a_pkg::ST_RED:   state_next = p2a_pkg::ST_SEP_G;
                            p2a_pkg::ST_SEP_G: state_next = p2a_pkg::ST_GRN;
                            p2a_pkg::ST_GRN:   state_next = p2a_pkg::ST_SEP_B;
                            p2a_pkg::ST_SEP_B: state_next = p2a_pkg::ST_BLU;
                            p2a_pkg::ST_BLU:   state_next = p2a_pkg::ST_TERM;
                            p2a_pkg::ST_TERM:  state_next = p2a_pkg::ST_CHAR;
                            p2a_pkg::ST_CHAR:
                                state_next = with_reset ? p2a_pkg::ST_RST : p2a_pkg::ST_IDLE;
                            default:           state_next = p2a_pkg::ST_IDLE;
                        endcase
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.ready = (state_reg == p2a_pkg::ST_IDLE);
        cmd.emit  = is_emit && status.out_free;
        cmd.seg   = state_reg;
        cmd.idx   = idx_reg;
        cmd.last  = ((state_reg == p2a_pkg::ST_CHAR) && !with_reset)
                 || ((state_reg == p2a_pkg::ST_RST) && seg_end);
        cmd.line_end = cmd.last && status.close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p2a_pkg::ST_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- design/p2a_datapath.sv -----
// datapath: config registers, raster counters, blend, luminance, digits, output word
// depends on p2a_pkg
module p2a_datapath #(
    parameter int MAX_COLUMNS        = p2a_pkg::MAX_COLUMNS_DEFAULT,
    parameter int COORD_BITS         = p2a_pkg::COORD_BITS_DEFAULT,
    parameter int STEP_FRACTION_BITS = p2a_pkg::STEP_FRACTION_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 frame_start,
    input  logic [7:0]           first_channel,
    input  logic [7:0]           second_channel,
    input  logic [7:0]           third_channel,
    input  logic [7:0]           fourth_channel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           text_byte,
    output logic                 line_end,
    output logic                 run_last,
    input  p2a_pkg::p2a_cmd_t    cmd,
    output p2a_pkg::p2a_status_t status
);

    localparam int PW = COORD_BITS + STEP_FRACTION_BITS;
    localparam int SW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int RW = (STEP_FRACTION_BITS + 1 > 24) ? STEP_FRACTION_BITS + 1 : 24;
    localparam int AW = ((PW > RW) ? PW : RW) + 1;
    localparam logic [SW-1:0] SIZE_LIMIT = SW'(1) << COORD_BITS;
    localparam logic [SW-1:0] COL_LIMIT  = SW'(MAX_COLUMNS);
    localparam logic [RW-1:0] STEP_ONE   = RW'(1) << STEP_FRACTION_BITS;

    function automatic logic [7:0] blend8(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] x;
        logic [16:0] s;
        x = 16'({8'd0, c} * {8'd0, a}) + 16'({8'd0, 8'd255} * {8'd0, ~a});
        s = 17'(x) + 17'(x >> 8) + 17'd1;
        return s[15:8];
    endfunction

    // {digit count, hundreds, tens, ones}
    function automatic logic [13:0] to_decimal(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] r;
        logic [1:0] n;
        h = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
        r = v - 8'(h * 8'd100);
        t = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (r >= 8'(10 * k))
                t = 4'(k);
        end
        n = (v >= 8'd100) ? 2'd3 : (v >= 8'd10) ? 2'd2 : 2'd1;
        return {n, h, t, 4'(r - 8'(t) * 8'd10)};
    endfunction

    // configuration
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  chan_reg;
    logic        color_reg;
    logic [23:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            chan_reg   <= 3'd3;
            color_reg  <= 1'b1;
            step_reg   <= 24'd65536;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                p2a_pkg::CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[12:0];
                p2a_pkg::CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[12:0];
                p2a_pkg::CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[2:0];
                p2a_pkg::CFG_COLOR_MODE:    color_reg  <= cfg_data[0];
                p2a_pkg::CFG_COLUMN_STEP:   step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // raster position state
    logic [COORD_BITS-1:0] sc_reg, sc_next, sr_reg, sr_next;
    logic [PW-1:0]         ncp_reg, ncp_next, nrp_reg, nrp_next;
    logic [6:0]            oc_reg, oc_next;
    logic                  rs_reg, rs_next;

    logic [COORD_BITS-1:0] sc_e, sr_e, sr_inc;
    logic [PW-1:0]         ncp_e, nrp_e, ncp_add, nrp_add, nrp_new;
    logic [6:0]            oc_e, oc_inc;
    logic                  rs_e;
    logic [SW-1:0]         w_ext, h_ext, w_c, h_c, outw;
    logic [RW-1:0]         half_step, row_step;
    logic                  last_col, last_row, sample_hit, close_now;
    logic                  accept, sample;

    assign in_stall = !cmd.ready;
    assign accept   = in_valid && cmd.ready;

    always_comb
    begin
        w_ext = SW'(width_reg);
        h_ext = SW'(height_reg);
        w_c   = (w_ext == '0) ? SW'(1) : (w_ext > SIZE_LIMIT) ? SIZE_LIMIT : w_ext;
        h_c   = (h_ext == '0) ? SW'(1) : (h_ext > SIZE_LIMIT) ? SIZE_LIMIT : h_ext;
        outw  = (w_c < COL_LIMIT) ? w_c : COL_LIMIT;

        half_step = RW'(step_reg >> 1);
        row_step  = (half_step < STEP_ONE) ? STEP_ONE : half_step;

        // a frame start restarts the counters before this pixel is taken
        sc_e  = frame_start ? '0 : sc_reg;
        sr_e  = frame_start ? '0 : sr_reg;
        ncp_e = frame_start ? '0 : ncp_reg;
        nrp_e = frame_start ? '0 : nrp_reg;
        oc_e  = frame_start ? 7'd0 : oc_reg;
        rs_e  = frame_start ? 1'b1 : rs_reg;

        last_col = SW'(sc_e) >= (w_c - SW'(1));
        last_row = SW'(sr_e) >= (h_c - SW'(1));
        oc_inc   = oc_e + 7'd1;
        sample_hit = rs_e && (SW'(oc_e) < outw)
                  && ((ncp_e[PW-1:STEP_FRACTION_BITS] <= sc_e) || last_col);
        close_now  = (SW'(oc_inc) >= outw) || last_col;

        ncp_add = PW'(AW'(ncp_e) + AW'(step_reg));
        nrp_add = PW'(AW'(nrp_e) + AW'(row_step));
        nrp_new = rs_e ? nrp_add : nrp_e;
        sr_inc  = sr_e + COORD_BITS'(1);

        sc_next  = sc_reg;
        sr_next  = sr_reg;
        ncp_next = ncp_reg;
        nrp_next = nrp_reg;
        oc_next  = oc_reg;
        rs_next  = rs_reg;
        if (accept)
        begin
            sc_next  = sc_e + COORD_BITS'(1);
            sr_next  = sr_e;
            ncp_next = sample_hit ? ncp_add : ncp_e;
            nrp_next = nrp_e;
            oc_next  = sample_hit ? oc_inc : oc_e;
            rs_next  = rs_e;
            if (last_col)
            begin
                sc_next  = '0;
                ncp_next = '0;
                oc_next  = 7'd0;
                if (last_row)
                begin
                    sr_next  = '0;
                    nrp_next = '0;
                    rs_next  = 1'b1;
                end
                else
                begin
                    sr_next  = sr_inc;
                    nrp_next = nrp_new;
                    rs_next  = nrp_new[PW-1:STEP_FRACTION_BITS] <= sr_inc;
                end
            end
        end
    end

    assign sample = accept && sample_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg  <= '0;
            sr_reg  <= '0;
            ncp_reg <= '0;
            nrp_reg <= '0;
            oc_reg  <= 7'd0;
            rs_reg  <= 1'b1;
        end
        else
        begin
            sc_reg  <= sc_next;
            sr_reg  <= sr_next;
            ncp_reg <= ncp_next;
            nrp_reg <= nrp_next;
            oc_reg  <= oc_next;
            rs_reg  <= rs_next;
        end
    end

    // pixel capture with channel expansion
    logic [7:0] pr_reg, pg_reg, pb_reg, pa_reg;
    logic       close_reg;

    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            close_reg <= close_now;
            if (chan_reg >= 3'd3)
            begin
                pr_reg <= first_channel;
                pg_reg <= second_channel;
                pb_reg <= third_channel;
                pa_reg <= (chan_reg >= 3'd4) ? fourth_channel : 8'd255;
            end
            else
            begin
                pr_reg <= first_channel;
                pg_reg <= first_channel;
                pb_reg <= first_channel;
                pa_reg <= (chan_reg == 3'd2) ? second_channel : 8'd255;
            end
        end
    end

    // blend over white
    logic [7:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.seg == p2a_pkg::ST_MIX)
        begin
            red_reg   <= blend8(pr_reg, pa_reg);
            green_reg <= blend8(pg_reg, pa_reg);
            blue_reg  <= blend8(pb_reg, pa_reg);
        end
    end

    // luminance, ramp pick and decimal digits
    logic [23:0] luma;
    logic [3:0]  ramp_idx;
    logic [7:0]  char_reg;
    logic [13:0] dec_reg [3];

    always_comb
    begin
        luma = 24'(red_reg) * p2a_pkg::LUMA_RED + 24'(green_reg) * p2a_pkg::LUMA_GREEN
             + 24'(blue_reg) * p2a_pkg::LUMA_BLUE;
        ramp_idx = 4'd0;
        for (int k = 1; k <= p2a_pkg::RAMP_STEPS; k++)
        begin
            if (luma >= p2a_pkg::luma_threshold(k))
                ramp_idx = 4'(k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg == p2a_pkg::ST_LUMA)
        begin
            char_reg   <= p2a_pkg::ramp_char(ramp_idx);
            dec_reg[0] <= to_decimal(red_reg);
            dec_reg[1] <= to_decimal(green_reg);
            dec_reg[2] <= to_decimal(blue_reg);
        end
    end

    // text word select
    logic [1:0]  chan_sel;
    logic [13:0] dec_sel;
    logic [1:0]  digit_pos;
    logic [3:0]  digit;
    logic [7:0]  word;

    always_comb
    begin
        case (cmd.seg)
            p2a_pkg::ST_GRN: chan_sel = 2'd1;
            p2a_pkg::ST_BLU: chan_sel = 2'd2;
            default:         chan_sel = 2'd0;
        endcase
        dec_sel   = dec_reg[chan_sel];
        digit_pos = dec_sel[13:12] - 2'd1 - cmd.idx[1:0];
        case (digit_pos)
            2'd2:    digit = dec_sel[11:8];
            2'd1:    digit = dec_sel[7:4];
            default: digit = dec_sel[3:0];
        endcase

        case (cmd.seg)
            p2a_pkg::ST_PRE:
            begin
                case (cmd.idx)
                    3'd0:    word = p2a_pkg::CH_ESC;
                    3'd1:    word = p2a_pkg::CH_LBRK;
                    3'd2:    word = p2a_pkg::CH_THREE;
                    3'd3:    word = p2a_pkg::CH_EIGHT;
                    3'd5:    word = p2a_pkg::CH_TWO;
                    default: word = p2a_pkg::CH_SEMI;
                endcase
            end
            p2a_pkg::ST_RED, p2a_pkg::ST_GRN, p2a_pkg::ST_BLU:
                word = p2a_pkg::CH_ZERO + 8'(digit);
            p2a_pkg::ST_SEP_G, p2a_pkg::ST_SEP_B:
                word = p2a_pkg::CH_SEMI;
            p2a_pkg::ST_TERM:
                word = p2a_pkg::CH_M;
            p2a_pkg::ST_RST:
            begin
                case (cmd.idx)
                    3'd0:    word = p2a_pkg::CH_ESC;
                    3'd1:    word = p2a_pkg::CH_LBRK;
                    3'd2:    word = p2a_pkg::CH_ZERO;
                    default: word = p2a_pkg::CH_M;
                endcase
            end
            default:
                word = char_reg;
        endcase
    end

    // output word register
    logic       out_valid_reg;
    logic [7:0] text_reg;
    logic       line_end_reg, run_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            text_reg     <= word;
            line_end_reg <= cmd.line_end;
            run_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_byte = text_reg;
    assign line_end  = line_end_reg;
    assign run_last  = run_last_reg;

    always_comb
    begin
        status.sampled    = sample;
        status.out_free   = !out_valid_reg || !out_stall;
        status.color      = color_reg;
        status.close      = close_reg;
        status.ndig_red   = dec_reg[0][13:12];
        status.ndig_green = dec_reg[1][13:12];
        status.ndig_blue  = dec_reg[2][13:12];
    end

endmodule

// ----- design/pixel_to_ascii_art_stream.sv -----
// pixel to ascii art stream: while idle, unsampled pixels are taken one per cycle with no output
// a sampled pixel stalls input through blend, luminance and all its words, one word per cycle
// unless the receiver stalls: 1 word in mono mode, 14 to 24 words in color mode, paced by the output register
// first word of a sampled pixel passes the capture, blend, luminance and output registers in that order
// reset: raster counters zero, row zero selected, registers width 1, height 1,
// three channels, color mode on, column step 1.0
module pixel_to_ascii_art_stream #(
    parameter int MAX_COLUMNS        = p2a_pkg::MAX_COLUMNS_DEFAULT,
    parameter int COORD_BITS         = p2a_pkg::COORD_BITS_DEFAULT,
    parameter int STEP_FRACTION_BITS = p2a_pkg::STEP_FRACTION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // pixel words in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_start,
    input  logic [7:0]  first_channel,
    input  logic [7:0]  second_channel,
    input  logic [7:0]  third_channel,
    input  logic [7:0]  fourth_channel,
    // text words out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_byte,
    output logic        line_end,
    output logic        run_last
);

    // command and status between sequencer and datapath
    p2a_pkg::p2a_cmd_t    cmd;
    p2a_pkg::p2a_status_t status;

    // sequencer: idle, blend, luminance, then escape words in color mode and the character word
    p2a_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // config registers, counters, color math and the output register
    p2a_datapath #(
        .MAX_COLUMNS        (MAX_COLUMNS),
        .COORD_BITS         (COORD_BITS),
        .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_start    (frame_start),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .fourth_channel (fourth_channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_byte      (text_byte),
        .line_end       (line_end),
        .run_last       (run_last),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ----- verif/pixel_to_ascii_art_stream_tb.sv -----
// self-checking testbench for pixel_to_ascii_art_stream: random and directed pixels
// with a scoreboard class that predicts every text word; depends on p2a_pkg and the design
module pixel_to_ascii_art_stream_tb;

    // one expected text word
    typedef struct {
        logic [7:0] text;
        logic       eol;
        logic       last;
    } text_word_t;

    // ascii art predictor and scoreboard for the text stream
    class art_scoreboard;
        text_word_t  pending_words[$];
        int          errors;
        int          words_checked;
        int          pixels_taken;
        int          pixels_sampled;
        // configuration copy
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic [2:0]  chan_reg;
        logic        color_reg;
        logic [23:0] step_reg;
        // raster state
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic [27:0] col_pos;
        logic [27:0] row_pos;
        logic [6:0]  out_col;
        logic        row_on;

        function new();
            width_reg = 1;
            height_reg = 1;
            chan_reg = 3;
            color_reg = 1;
            step_reg = 24'd65536;
            errors = 0;
            words_checked = 0;
            pixels_taken = 0;
            pixels_sampled = 0;
            restart();
        endfunction

        function void restart();
            src_col = 0;
            src_row = 0;
            col_pos = 0;
            row_pos = 0;
            out_col = 0;
            row_on = 1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                p2a_pkg::CFG_IMAGE_WIDTH:   width_reg = data[12:0];
                p2a_pkg::CFG_IMAGE_HEIGHT:  height_reg = data[12:0];
                p2a_pkg::CFG_CHANNEL_COUNT: chan_reg = data[2:0];
                p2a_pkg::CFG_COLOR_MODE:    color_reg = data[0];
                p2a_pkg::CFG_COLUMN_STEP:   step_reg = data;
                default: ;
            endcase
        endfunction

        function void push_word(logic [7:0] b);
            text_word_t w;
            w.text = b;
            w.eol = 0;
            w.last = 0;
            pending_words.push_back(w);
        endfunction

        function void push_decimal(int unsigned v);
            if (v >= 100) push_word(8'(p2a_pkg::CH_ZERO + v / 100));
            if (v >= 10) push_word(8'(p2a_pkg::CH_ZERO + (v / 10) % 10));
            push_word(8'(p2a_pkg::CH_ZERO + v % 10));
        endfunction

        function int unsigned clamp_size(logic [12:0] v);
            if (v == 0) return 1;
            if (v > 4096) return 4096;
            return 32'(v);
        endfunction

        function int unsigned over_white(int unsigned c, int unsigned a);
            return (c * a + 255 * (255 - a)) / 255;
        endfunction

        // note one accepted pixel and queue the text it causes
        function void note_pixel(logic fs, logic [7:0] c0, logic [7:0] c1,
                                 logic [7:0] c2, logic [7:0] c3);
            string       ramp;
            int unsigned w, h, line_len, r, g, b, a;
            longint unsigned row_step, luma;
            bit          end_col, end_row;
            ramp = " .:-=+*#%@";
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            line_len = (w < 80) ? w : 80;
            row_step = step_reg >> 1;
            if (row_step < 65536) row_step = 65536;
            pixels_taken++;
            if (fs) restart();
            end_col = src_col >= w - 1;
            end_row = src_row >= h - 1;
            if (row_on && out_col < line_len && (col_pos[27:16] <= src_col || end_col)) begin
                pixels_sampled++;
                a = 255;
                if (chan_reg >= 3) begin
                    r = c0; g = c1; b = c2;
                    if (chan_reg >= 4) a = c3;
                end
                else begin
                    r = c0; g = c0; b = c0;
                    if (chan_reg == 2) a = c1;
                end
                if (a < 255) begin
                    r = over_white(r, a);
                    g = over_white(g, a);
                    b = over_white(b, a);
                end
                luma = 13933 * r + 46871 * g + 4732 * b;
                if (color_reg) begin
                    push_word(p2a_pkg::CH_ESC); push_word(p2a_pkg::CH_LBRK);
                    push_word(p2a_pkg::CH_THREE); push_word(p2a_pkg::CH_EIGHT);
                    push_word(p2a_pkg::CH_SEMI); push_word(p2a_pkg::CH_TWO);
                    push_word(p2a_pkg::CH_SEMI);
                    push_decimal(r); push_word(p2a_pkg::CH_SEMI);
                    push_decimal(g); push_word(p2a_pkg::CH_SEMI);
                    push_decimal(b); push_word(p2a_pkg::CH_M);
                end
                push_word(ramp[((luma * 9) / (255 * 65536)) % 10]);
                out_col = out_col + 1;
                col_pos = col_pos + step_reg;
                if (out_col >= line_len || end_col) begin
                    if (color_reg) begin
                        push_word(p2a_pkg::CH_ESC); push_word(p2a_pkg::CH_LBRK);
                        push_word(p2a_pkg::CH_ZERO); push_word(p2a_pkg::CH_M);
                    end
                    pending_words[$].eol = 1;
                end
                pending_words[$].last = 1;
            end
            if (end_col) begin
                if (row_on) row_pos = row_pos + 28'(row_step);
                out_col = 0;
                col_pos = 0;
                src_col = 0;
                if (end_row) restart();
                else begin
                    src_row = src_row + 1;
                    row_on = row_pos[27:16] <= src_row;
                end
            end
            else src_col = src_col + 1;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // compare one accepted text word with the oldest expectation
        task check_word(logic [7:0] b, logic eol, logic last);
            text_word_t e;
            words_checked++;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %h", b));
            end
            else begin
                e = pending_words.pop_front();
                if (b !== e.text)
                    report($sformatf("text_byte %h, want %h", b, e.text));
                if (eol !== e.eol)
                    report($sformatf("line_end %b, want %b", eol, e.eol));
                if (last !== e.last)
                    report($sformatf("run_last %b, want %b", last, e.last));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        frame_start;
    logic [7:0]  first_channel;
    logic [7:0]  second_channel;
    logic [7:0]  third_channel;
    logic [7:0]  fourth_channel;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  text_byte;
    logic        line_end;
    logic        run_last;

    art_scoreboard sb;
    int          idle_mode;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int          hold_left;   // long receiver hold-off, in cycles
    int          phase_count;

    pixel_to_ascii_art_stream u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_start    (frame_start),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .fourth_channel (fourth_channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_byte      (text_byte),
        .line_end       (line_end),
        .run_last       (run_last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver: a long hold-off wins over the random stall pattern
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (idle_mode == 2)
            out_stall <= ($urandom_range(0, 99) < 73);
        else if (idle_mode == 3)
            out_stall <= ($urandom_range(0, 99) < 9);
        else
            out_stall <= 1'b0;
    end

    // output monitor, values sampled as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(text_byte, line_end, run_last);
    end

    // offer one pixel word and hold it until accepted; valid stays high afterwards
    task send_pixel(logic fs, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                    logic [7:0] c3);
        int gap;
        gap = (idle_mode == 1) ? 73 : (idle_mode == 3) ? 9 : 0;
        while ($urandom_range(0, 99) < gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        frame_start    <= fs;
        first_channel  <= c0;
        second_channel <= c1;
        third_channel  <= c2;
        fourth_channel <= c3;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(fs, c0, c1, c2, c3);
    endtask

    // lower valid and wait until every expected word is out, plus the pipeline depth
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // write all five registers back to back while the block is idle
    task set_config(logic [12:0] w, logic [12:0] h, logic [2:0] cc, logic cm,
                    logic [23:0] step);
        logic [23:0] vals[5];
        vals[p2a_pkg::CFG_IMAGE_WIDTH]   = 24'(w);
        vals[p2a_pkg::CFG_IMAGE_HEIGHT]  = 24'(h);
        vals[p2a_pkg::CFG_CHANNEL_COUNT] = 24'(cc);
        vals[p2a_pkg::CFG_COLOR_MODE]    = 24'(cm);
        vals[p2a_pkg::CFG_COLUMN_STEP]   = step;
        for (int i = 0; i < 5; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= 3'(i);
            cfg_data     <= vals[i];
            @(posedge clk);
            sb.write_reg(3'(i), vals[i]);
        end
        cfg_write_en <= 1'b0;
        phase_count++;
    endtask

    // random pixel with alpha mostly opaque so colors stay varied
    task send_random(logic fs);
        logic [7:0] c1, c3;
        c1 = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        c3 = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        send_pixel(fs, 8'($urandom), c1, 8'($urandom), c3);
    endtask

    initial
    begin
        logic [23:0] step;
        logic [12:0] w;
        int          n;
        sb = new();
        idle_mode = 0;
        hold_left = 0;
        phase_count = 0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = p2a_pkg::CFG_IMAGE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        frame_start = 1'b0;
        first_channel = '0;
        second_channel = '0;
        third_channel = '0;
        fourth_channel = '0;
        out_stall = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: one pixel image, rgb, color on
        send_pixel(1'b1, 8'd1, 8'd22, 8'd255, 8'd0);
        drain();

        // rgba extremes: black, white, fully clear, partial alpha, short decimals
        set_config(13'd3, 13'd2, 3'd4, 1'b1, 24'd65536);
        send_pixel(1'b1, 8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd200, 8'd100, 8'd50, 8'd128);
        send_pixel(1'b0, 8'd17, 8'd9, 8'd255, 8'd254);
        send_pixel(1'b0, 8'd1, 8'd2, 8'd3, 8'd255);
        drain();

        // gray plus alpha, mono
        set_config(13'd2, 13'd2, 3'd2, 1'b0, 24'd65536);
        send_pixel(1'b1, 8'd0, 8'd0, 8'd77, 8'd1);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd128, 8'd1, 8'd9, 8'd9);
        send_pixel(1'b0, 8'd99, 8'd200, 8'd9, 8'd9);
        drain();

        // zero channel count and zero sizes act as gray, one by one
        set_config(13'd0, 13'd0, 3'd0, 1'b1, 24'd65536);
        send_pixel(1'b1, 8'd60, 8'd255, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd255, 8'd0, 8'd0, 8'd0);
        drain();

        // oversized channel count and sizes, largest step
        set_config(13'h1FFF, 13'h1FFF, 3'd7, 1'b1, 24'hFFFFFF);
        for (int i = 0; i < 4; i++)
            send_random(i == 0);
        drain();

        // step below one, with a restart in mid frame
        set_config(13'd5, 13'd2, 3'd1, 1'b0, 24'd0);
        for (int i = 0; i < 7; i++)
            send_random(i == 0 || i == 4);
        drain();

        // size lowered in mid frame: coordinates past the new edge count as the last
        set_config(13'd6, 13'd3, 3'd3, 1'b1, 24'd65536);
        for (int i = 0; i < 4; i++)
            send_random(i == 0);
        drain();
        set_config(13'd2, 13'd2, 3'd3, 1'b1, 24'd65536);
        for (int i = 0; i < 3; i++)
            send_random(1'b0);
        drain();

        // random phases with varied settings and idling patterns
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 3))
                0: step = 24'd65536;
                1: step = 24'($urandom_range(0, 65535));
                2: step = 24'($urandom_range(65536, 300000));
                default: step = 24'hFFFFFF;
            endcase
            w = (p == 5) ? 13'd100 : 13'($urandom_range(1, 12));
            set_config(w, 13'($urandom_range(1, 4)), 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)), step);
            idle_mode = p % 4;
            n = (p == 5) ? 30 : 11;
            for (int i = 0; i < n; i++)
            begin
                // a long receiver hold-off fills the block and stalls its input
                if (p == 2 && i == 3)
                    hold_left = 300;
                // pause the sender until all text is out
                if (p == 4 && i == 8)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending_words.size() != 0)
                        @(posedge clk);
                end
                send_random(i == 0 || $urandom_range(0, 19) == 0);
            end
            drain();
        end

        idle_mode = 0;
        repeat (30) @(posedge clk);
        $display("covered %0d config phases, %0d pixels (%0d sampled), %0d text words checked",
                 phase_count, sb.pixels_taken, sb.pixels_sampled, sb.words_checked);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("PASS pixel_to_ascii_art_stream");
        else
            $display("FAIL pixel_to_ascii_art_stream");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("timeout");
        $display("FAIL pixel_to_ascii_art_stream");
        $finish;
    end

endmodule
